// ===== src/stb_pkg.sv =====
// Shared types for the sorted table bisect block.
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

   localparam int MODE_WIDTH = 2;

   typedef enum logic [MODE_WIDTH-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_LOWER  = 2'd2,
      OP_UPPER  = 2'd3
   } op_type;

   // Head of the command queue as seen by the search engine.
   typedef struct packed {
      logic   valid;
      op_type op;
   } item_ctl_type;

endpackage

`default_nettype wire

// ===== src/stb_front.sv =====
// Command front end: takes request beats, decodes the mode, queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none

module stb_front
   import stb_pkg::*;
#(
   parameter int KEY_WIDTH = 32
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire  [MODE_WIDTH-1:0]      req_mode,
   input  wire  signed [KEY_WIDTH-1:0] req_key,
   output item_ctl_type               head,
   output logic signed [KEY_WIDTH-1:0] head_key,
   input  wire                        pop
);

   op_type                      op_ff  [2];
   logic signed [KEY_WIDTH-1:0] key_ff [2];
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [1:0]                  fill_ff, fill_in;
   logic                        push;

   assign busy     = (fill_ff == 2'd2);
   assign push     = start && !busy;
   assign head     = '{valid: (fill_ff != 2'd0), op: op_ff[rd_ptr_ff]};
   assign head_key = key_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Payload slots carry no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]  <= op_type'(req_mode);
         key_ff[wr_ptr_ff] <= req_key;
      end
   end

endmodule

`default_nettype wire

// ===== src/stb_back.sv =====
// Search engine: key memory, entry count and the bisect probe sequencer.
`timescale 1ns / 1ps
`default_nettype none

module stb_back
   import stb_pkg::*;
#(
   parameter  int DEPTH     = 1024,
   parameter  int KEY_WIDTH = 32,
   localparam int POS_W     = $clog2(DEPTH + 1),
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                         clock,
   input  wire                         reset,
   input  item_ctl_type                head,
   input  wire  signed [KEY_WIDTH-1:0] head_key,
   output logic                        pop,
   output logic                        rsp_strobe,
   output logic [POS_W-1:0]            rsp_position
);

   typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_FINAL} state_type;

   localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);

   logic signed [KEY_WIDTH-1:0] mem [DEPTH];
   logic signed [KEY_WIDTH-1:0] rd_data_ff;

   state_type                   state_ff, state_in;
   logic [POS_W-1:0]            count_ff, count_in;
   logic [POS_W-1:0]            top_ff, top_in;
   logic [POS_W-1:0]            n_ff, n_in;
   logic [POS_W-1:0]            begin_ff, begin_in;
   logic [POS_W-1:0]            step_ff, step_in;
   logic [POS_W-1:0]            tgt_ff, tgt_in;
   logic                        pend_ff, pend_in;
   logic                        set_hit_ff, set_hit_in;
   logic                        hit_ff, hit_in;
   logic                        upper_ff, upper_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [POS_W-1:0]            rsp_pos_ff, rsp_pos_in;

   logic                        wr_en, rd_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic                        probe_hit;
   logic [POS_W-1:0]            b_cur, count_inc;
   logic                        h_cur;
   logic [POS_W:0]              next_sum;
   logic                        next_lt_n;

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_position = rsp_pos_ff;

   always_comb begin
      probe_hit = upper_ff ? (rd_data_ff <= key_ff) : (rd_data_ff < key_ff);
      b_cur     = (pend_ff && probe_hit) ? tgt_ff : begin_ff;
      h_cur     = hit_ff | (pend_ff & probe_hit & set_hit_ff);
      next_sum  = {1'b0, b_cur} + {1'b0, step_ff};
      next_lt_n = next_sum < {1'b0, n_ff};
      count_inc = count_ff + POS_W'(1);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      n_in          = n_ff;
      begin_in      = begin_ff;
      step_in       = step_ff;
      tgt_in        = tgt_ff;
      pend_in       = pend_ff;
      set_hit_in    = set_hit_ff;
      hit_in        = hit_ff;
      upper_in      = upper_ff;
      key_in        = key_ff;
      rsp_strobe_in = 1'b0;
      rsp_pos_in    = rsp_pos_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      rd_en         = 1'b0;
      rd_addr       = next_sum[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               unique case (head.op)
                  OP_CLEAR: begin
                     count_in = '0;
                     top_in   = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff < DEPTH_POS) begin
                        wr_en    = 1'b1;
                        count_in = count_inc;
                        // Track the largest power of two not above the count.
                        if ((count_inc & count_ff) == '0) begin
                           top_in = count_inc;
                        end
                     end
                  end
                  OP_LOWER, OP_UPPER: begin
                     key_in   = head_key;
                     upper_in = (head.op == OP_UPPER);
                     n_in     = count_ff;
                     begin_in = '0;
                     hit_in   = 1'b0;
                     step_in  = top_ff >> 1;
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_pos_in    = '0;
                     end else begin
                        state_in   = S_SEARCH;
                        pend_in    = 1'b0;
                        set_hit_in = 1'b0;
                        tgt_in     = top_ff;
                        if (top_ff != count_ff) begin
                           rd_en   = 1'b1;
                           rd_addr = AW'(top_ff - POS_W'(1));
                           pend_in = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         S_SEARCH: begin
            begin_in = b_cur;
            hit_in   = h_cur;
            if (step_ff == '0) begin
               pend_in = 1'b0;
               if (h_cur) begin
                  rsp_strobe_in = 1'b1;
                  rsp_pos_in    = b_cur + POS_W'(b_cur < n_ff);
                  state_in      = S_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = b_cur[AW-1:0];
                  state_in = S_FINAL;
               end
            end else begin
               step_in    = step_ff >> 1;
               pend_in    = next_lt_n;
               set_hit_in = 1'b1;
               tgt_in     = next_sum[POS_W-1:0];
               rd_en      = next_lt_n;
            end
         end
         S_FINAL: begin
            rsp_strobe_in = 1'b1;
            rsp_pos_in    = begin_ff + POS_W'(probe_hit && (begin_ff < n_ff));
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         top_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         top_ff        <= top_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      n_ff       <= n_in;
      begin_ff   <= begin_in;
      step_ff    <= step_in;
      tgt_ff     <= tgt_in;
      pend_ff    <= pend_in;
      set_hit_ff <= set_hit_in;
      hit_ff     <= hit_in;
      upper_ff   <= upper_in;
      key_ff     <= key_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= head_key;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/sorted_table_bisect_core.sv =====
// Top level of the sorted table bisect block.
`timescale 1ns / 1ps
`default_nettype none

// Sorted table bisect core. Holds up to DEPTH signed keys, expected in
// ascending order, plus the count of entries in use. Each request beat
// carries a mode and a key: clear empties the table, append writes the key
// after the last entry (dropped once the table is full), and the lower- and
// upper-bound queries return the insertion position of the key, from 0 to
// the entry count. Only queries produce a response beat; it appears on
// rsp_position for exactly one cycle with rsp_strobe high, and the receiver
// cannot stall it, so capture it on that cycle. A request is taken when
// start is high and busy is low; busy goes high only while the two-entry
// command queue is full. Requests pass through the queue and are then
// executed in order by the search engine, which finishes each request
// before it takes the next. Clear and append complete as the engine takes
// them. A query launches by probing the top entry of the largest
// power-of-two span, unless the entry count is itself a power of two,
// then steps through halving strides, probing each that stays within the
// table, with a last settling probe only when no stride probe succeeds.
// An empty table is answered at launch, with no probe. The response
// strobe follows in the cycle after the engine's last cycle. The pace of
// a query is set by the single read port of the key memory, whose
// registered output feeds the next dependent probe address.
// The key memory needs no clearing after reset: a query only probes
// entries written since the last clear or reset.

module sorted_table_bisect_core
   import stb_pkg::*;
#(
   parameter  int DEPTH     = 1024,
   parameter  int KEY_WIDTH = 32,
   localparam int POS_W     = $clog2(DEPTH + 1)
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire  [MODE_WIDTH-1:0]       req_mode,
   input  wire  signed [KEY_WIDTH-1:0] req_key,
   output logic                        rsp_strobe,
   output logic [POS_W-1:0]            rsp_position
);

   item_ctl_type                head;
   logic signed [KEY_WIDTH-1:0] head_key;
   logic                        pop;

   // Front: decode and queue request beats.
   stb_front #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_mode (req_mode),
      .req_key  (req_key),
      .head     (head),
      .head_key (head_key),
      .pop      (pop)
   );

   // Back: drain the queue in order, own the table and run the search.
   stb_back #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_key     (head_key),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_position (rsp_position)
   );

endmodule

`default_nettype wire

// ===== src/stb_checker.sv =====
// Port-level checks for the sorted table bisect core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module stb_checker #(
   parameter  int DEPTH = 1024,
   localparam int POS_W = $clog2(DEPTH + 1)
) (
   input wire             clock,
   input wire             reset,
   input wire             start,
   input wire             busy,
   input wire             rsp_strobe,
   input wire [POS_W-1:0] rsp_position
);

   // Reset leaves the queue empty and no response pending.
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> (!rsp_strobe && !busy))
      else $error("response or busy right after reset");

   // The queue only fills from an accepted beat.
   a_busy_needs_beat : assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !busy)
      else $error("busy raised without an accepted beat");

   // A query position never exceeds the table capacity.
   a_position_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_position <= POS_W'(DEPTH)))
      else $error("response position beyond table capacity");

endmodule

bind sorted_table_bisect_core stb_checker #(
   .DEPTH (DEPTH)
) u_stb_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_position (rsp_position)
);

`default_nettype wire

// ===== dv/sorted_table_bisect_core_test.sv =====
// Self-checking testbench for the sorted table bisect core.
`timescale 1ns / 1ps

// Request beats come from a queue of pending items that the stimulus block
// fills up front. A clocked driver presents them with start/busy and random
// idle bursts. A clocked monitor takes every response beat on the cycle its
// strobe is high. A predictor applies each accepted beat to its own copy of
// the key table. For queries it pushes the expected insertion position, and
// the monitor compares responses against these in order.
module sorted_table_bisect_core_test;
   import stb_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int KEY_W        = 32;
   localparam int POS_W        = $clog2(DEPTH + 1);
   localparam int RANDOM_ITEMS = 1800;
   localparam int QUIET_LIMIT  = 1000;  // cycles with no beat in either direction
   localparam int DRAIN_CYCLES = 40;    // well past the longest query latency
   localparam int CALM_TAIL    = 150;   // last beats go out without idling
   localparam int PRINT_CAP    = 40;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   typedef struct {
      op_type                  mode;
      logic signed [KEY_W-1:0] key;
   } table_beat_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic [MODE_WIDTH-1:0]   req_mode = OP_CLEAR;
   logic signed [KEY_W-1:0] req_key = '0;
   wire                     busy;
   wire                     rsp_strobe;
   wire  [POS_W-1:0]        rsp_position;

   sorted_table_bisect_core #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_W)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_key      (req_key),
      .rsp_strobe   (rsp_strobe),
      .rsp_position (rsp_position)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: a private copy of the table and its entry count.
   // ---------------------------------------------------------------------
   logic signed [KEY_W-1:0] key_table [DEPTH];
   int unsigned             table_count = 0;
   logic [POS_W-1:0]        expected_positions [$];
   int                      mismatches = 0;

   // A probe passes when the entry lies strictly left of the insertion point:
   // entry <= key for upper bound, entry < key for lower bound.
   function automatic bit key_passes(int unsigned idx, logic signed [KEY_W-1:0] k, bit upper);
      return upper ? (key_table[idx] <= k) : (key_table[idx] < k);
   endfunction

   // Follow the block's fixed probe order exactly, so that unsorted tables
   // also give the same answer as the hardware.
   function automatic int unsigned bisect_position(logic signed [KEY_W-1:0] k, bit upper);
      int unsigned stride;
      int unsigned base;
      int unsigned probe_idx;
      int          hit;
      stride = 1;
      base   = 0;
      hit    = -1;
      if (table_count == 0)
         return 0;
      // Find the largest power of two not above the count.
      while ((stride << 1) <= table_count)
         stride = stride << 1;
      // When the count is not a power of two, probe the top of that span
      // first. Success shifts the window up to its end.
      if (stride != table_count && key_passes(stride - 1, k, upper))
         base = stride;
      for (stride = stride >> 1; stride != 0; stride = stride >> 1) begin
         probe_idx = base + stride;
         if (probe_idx < table_count && key_passes(probe_idx, k, upper)) begin
            base = probe_idx;
            hit  = 1;
         end
      end
      // No stride probe moved the window: settle with one last probe.
      if (hit < 0)
         hit = key_passes(base, k, upper);
      return base + ((base < table_count && hit != 0) ? 1 : 0);
   endfunction

   task automatic table_apply(op_type mode, logic signed [KEY_W-1:0] k);
      case (mode)
         OP_CLEAR: table_count = 0;
         OP_APPEND: begin
            // Drop appends once the table is full.
            if (table_count < DEPTH) begin
               key_table[table_count] = k;
               table_count++;
            end
         end
         default: expected_positions.push_back(POS_W'(bisect_position(k, mode == OP_UPPER)));
      endcase
   endtask

   task automatic report_mismatch(string what, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t ns: %s, expected %0d, got %0d", $time, what, want, got);
   endtask

   // ---------------------------------------------------------------------
   // Driver: present the head of the pending queue, hold it until taken.
   // ---------------------------------------------------------------------
   table_beat_type pending_items [$];
   int             gap_left    = 0;
   int             beats_taken = 0;
   int             total_beats = 0;
   bit             idle_ok;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         // A beat moves on this edge: predict it and retire it from the queue.
         if (start && !busy) begin
            table_apply(op_type'(req_mode), req_key);
            void'(pending_items.pop_front());
            beats_taken++;
         end
         // Idle in bursts, but leave every third stretch of 80 beats and the
         // tail of the run free of gaps.
         idle_ok = (beats_taken + CALM_TAIL < total_beats) && ((beats_taken / 80) % 3 != 2);
         if (start && busy) begin
            // Hold the current beat until the command queue frees up.
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_items.size() == 0) begin
            start <= 1'b0;
         end else if (idle_ok && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 2);
            start <= 1'b0;
         end else begin
            start    <= 1'b1;
            req_mode <= pending_items[0].mode;
            req_key  <= pending_items[0].key;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every strobed cycle is one response beat; it cannot be held.
   // ---------------------------------------------------------------------
   logic [POS_W-1:0] want_position;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_positions.size() == 0) begin
            report_mismatch("response beat with no query outstanding", '0, rsp_position);
         end else begin
            want_position = expected_positions.pop_front();
            if (rsp_position !== want_position)
               report_mismatch("rsp_position", want_position, rsp_position);
         end
      end
   end

   // Watchdog: give up when nothing moves in either direction for too long.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus generation.
   // ---------------------------------------------------------------------
   logic signed [KEY_W-1:0] session_keys [$];  // keys appended since the last generated clear
   int unsigned             pow_sizes [6] = '{63, 64, 65, 127, 128, 129};

   task automatic queue_beat(op_type mode, logic signed [KEY_W-1:0] k);
      table_beat_type b;
      b.mode = mode;
      b.key  = k;
      pending_items.push_back(b);
   endtask

   function automatic logic signed [KEY_W-1:0] random_key();
      logic signed [KEY_W-1:0] r;
      r = $urandom;
      return r;
   endfunction

   function automatic logic signed [KEY_W-1:0] clamp_key(longint v);
      if (v > KEY_MAX)
         return KEY_MAX;
      if (v < KEY_MIN)
         return KEY_MIN;
      return v[KEY_W-1:0];
   endfunction

   // Aim queries mostly at stored keys and their neighbors, where the lower
   // and upper bounds differ, with some random and extreme keys mixed in.
   function automatic logic signed [KEY_W-1:0] query_key();
      longint      pick;
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (session_keys.size() == 0 || sel >= 8)
         return random_key();
      pick = session_keys[$urandom_range(0, session_keys.size() - 1)];
      case (sel)
         0, 1, 2, 3: return pick;
         4, 5:       return clamp_key(pick - 1);
         6:          return clamp_key(pick + 1);
         default:    return ($urandom_range(0, 1) != 0) ? KEY_MIN : KEY_MAX;
      endcase
   endfunction

   // One session: optionally clear, append keys (ascending with duplicates,
   // or scrambled), then a run of queries.
   task automatic add_session(int unsigned n_keys, bit ordered, bit keep_table, bit from_min);
      longint      cur;
      int unsigned span;
      int unsigned i;
      int unsigned n_q;
      logic signed [KEY_W-1:0] k;
      if (!keep_table) begin
         queue_beat(OP_CLEAR, random_key());
         session_keys.delete();
      end
      if (keep_table && session_keys.size() != 0)
         cur = session_keys[session_keys.size() - 1];
      else if (from_min)
         cur = KEY_MIN;
      else
         cur = random_key();
      case ($urandom_range(0, 3))
         0:       span = 1;
         1:       span = 200;
         2:       span = 1 << 20;
         default: span = 1 << 23;
      endcase
      for (i = 0; i < n_keys; i++) begin
         if (ordered) begin
            k   = clamp_key(cur);
            cur = cur + $urandom_range(0, span);
         end else begin
            k = random_key();
         end
         queue_beat(OP_APPEND, k);
         session_keys.push_back(k);
      end
      n_q = $urandom_range(1, 10) + n_keys / 32;
      for (i = 0; i < n_q; i++)
         queue_beat(($urandom_range(0, 1) != 0) ? OP_UPPER : OP_LOWER, query_key());
   endtask

   initial begin
      int unsigned target;
      int unsigned choice;

      // Directed: empty table, single entry, extremes, duplicates at the
      // top, power-of-two and odd counts, clear, and an unsorted table.
      queue_beat(OP_LOWER, KEY_MIN);
      queue_beat(OP_UPPER, KEY_MAX);
      queue_beat(OP_APPEND, KEY_MIN);
      queue_beat(OP_LOWER, KEY_MIN);
      queue_beat(OP_UPPER, KEY_MIN);
      queue_beat(OP_LOWER, KEY_MAX);
      queue_beat(OP_APPEND, -1);
      queue_beat(OP_APPEND, 0);
      queue_beat(OP_APPEND, KEY_MAX);
      queue_beat(OP_LOWER, 0);
      queue_beat(OP_UPPER, 0);
      queue_beat(OP_UPPER, KEY_MAX);
      queue_beat(OP_APPEND, KEY_MAX);
      queue_beat(OP_LOWER, KEY_MAX);
      queue_beat(OP_UPPER, KEY_MAX);
      queue_beat(OP_CLEAR, KEY_MAX);
      queue_beat(OP_UPPER, 5);
      queue_beat(OP_APPEND, 10);
      queue_beat(OP_APPEND, 5);
      queue_beat(OP_APPEND, 7);
      queue_beat(OP_LOWER, 6);
      queue_beat(OP_UPPER, 10);

      // Random: fill the table once to capacity and push past it, then a
      // mix of mostly sorted sessions with some scrambled and noise beats.
      target = pending_items.size() + RANDOM_ITEMS;
      add_session(DEPTH + 3, 1'b1, 1'b0, 1'b1);
      while (pending_items.size() < target) begin
         choice = $urandom_range(0, 99);
         if (choice < 8)
            repeat ($urandom_range(1, 6))
               queue_beat(op_type'($urandom_range(0, 3)), random_key());
         else if (choice < 18)
            add_session($urandom_range(1, 8), $urandom_range(0, 1), 1'b1, 1'b0);
         else if (choice < 25)
            add_session($urandom_range(2, 12), 1'b0, 1'b0, 1'b0);
         else if (choice < 29)
            add_session(pow_sizes[$urandom_range(0, 5)], 1'b1, 1'b0, $urandom_range(0, 1));
         else
            add_session($urandom_range(0, 40), 1'b1, 1'b0, $urandom_range(0, 3) == 0);
      end
      total_beats = pending_items.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to go out and every query to be answered.
      while (pending_items.size() != 0 || expected_positions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
